>>> design/bcsp_pkg.sv
// ----------------------------------------------------------------------------
// bcsp_pkg: shared types, codes and helpers for the command string parser
// Holds the character codes, the action codes, the token state record and
// the per-character token arithmetic.
// ----------------------------------------------------------------------------
package bcsp_pkg;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Bus actions
    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_STOP  = 3'd1,
        ACT_READ  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_ERROR = 3'd4
    } t_action;

    // Parser mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_TOKEN = 3'b010,
        MODE_ERROR = 3'b100
    } t_mode;

    // Radix picked by the second character of a token
    typedef enum logic [1:0] {
        KIND_DEC = 2'd0,
        KIND_HEX = 2'd1,
        KIND_BIN = 2'd2
    } t_kind;

    // Character codes
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_UP_R   = 8'h52;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_DIG_HI = 8'h3F;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_H  = 8'h68;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_G   = 8'h47;
    localparam logic [7:0] HEX_UP_OFS  = 8'h37;
    localparam logic [7:0] HEX_LOW_OFS = 8'h57;

    // Token state
    typedef struct packed {
        logic [1:0] pos;
        t_kind      kind;
        logic [7:0] dec;
        logic [7:0] hex;
        logic [7:0] bin;
    } t_tok;

    localparam t_tok TOK_CLEAR = '{pos: 2'd0, kind: KIND_DEC,
                                   dec: 8'd0, hex: 8'd0, bin: 8'd0};

    // One result item
    typedef struct packed {
        t_action    action;
        logic [7:0] value;
        logic       last;
    } t_result;

    // Results raised by one accepted character
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Characters that a token keeps collecting
    function automatic logic is_numeric(input logic [7:0] c);
        return (c inside {[8'h30:8'h3F], [8'h41:8'h46], [8'h61:8'h66],
                          CH_LOW_X, CH_LOW_H, CH_CARET, CH_AMP, CH_LOW_R});
    endfunction

    // Take one character into the token accumulators (all mod 256)
    function automatic t_tok tok_absorb(input t_tok s, input logic [7:0] c);
        t_tok       r;
        logic [7:0] digit;
        r     = s;
        r.dec = (s.dec << 3) + (s.dec << 1) + (c - CH_ZERO);
        if (s.pos == 2'd1) begin
            if (c == CH_LOW_X || c == CH_LOW_H) begin
                r.kind = KIND_HEX;
            end else if (c == CH_LOW_B) begin
                r.kind = KIND_BIN;
            end else begin
                r.kind = KIND_DEC;
            end
        end else if (s.pos[1]) begin
            if (c < CH_AT) begin
                digit = c - CH_ZERO;
            end else if (c < CH_UP_G) begin
                digit = c - HEX_UP_OFS;
            end else begin
                digit = c - HEX_LOW_OFS;
            end
            r.hex = {s.hex[3:0], 4'd0} + digit;
            r.bin = {s.bin[6:0], (c == CH_ONE)};
        end
        if (!s.pos[1]) begin
            r.pos = s.pos + 2'd1;
        end
        return r;
    endfunction

    // Byte value of a token in its radix
    function automatic logic [7:0] tok_value(input t_tok s);
        logic [7:0] v;
        case (s.kind)
            KIND_HEX: v = s.hex;
            KIND_BIN: v = s.bin;
            default:  v = s.dec;
        endcase
        return v;
    endfunction

endpackage

>>> design/bcsp_parse.sv
// ----------------------------------------------------------------------------
// bcsp_parse: parser state and per-character decode
// Holds the parse mode and token accumulators and raises up to two results
// for each accepted character.
// ----------------------------------------------------------------------------
module bcsp_parse
    import bcsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  logic       i_eos,
    output t_push      o_push
);

    t_mode   r_mode, n_mode;
    t_tok    r_tok,  n_tok;
    t_tok    absorbed;
    logic    numeric;
    logic    handle_idle;
    logic    tok_emit,  idle_emit;
    t_result tok_res,   idle_res;
    t_push   push;

    assign numeric  = is_numeric(i_char);
    assign absorbed = tok_absorb(r_tok, i_char);

    // Decode the character against the current mode
    always_comb begin
        n_mode      = r_mode;
        n_tok       = r_tok;
        handle_idle = 1'b1;
        tok_emit    = 1'b0;
        tok_res     = '{action: ACT_WRITE, value: 8'd0, last: 1'b0};
        idle_emit   = 1'b0;
        idle_res    = '{action: ACT_START, value: 8'd0, last: 1'b0};

        case (r_mode)
            MODE_ERROR: begin
                handle_idle = 1'b0;
            end
            MODE_TOKEN: begin
                if (numeric) begin
                    n_tok         = absorbed;
                    handle_idle   = 1'b0;
                    tok_emit      = i_eos;
                    tok_res.value = tok_value(absorbed);
                end else begin
                    tok_emit      = 1'b1;
                    tok_res.value = tok_value(r_tok);
                    n_mode        = MODE_IDLE;
                end
            end
            default: ;
        endcase

        // Handle the character as a fresh one
        if (handle_idle) begin
            case (i_char)
                CH_LBRACK, CH_LBRACE: begin
                    idle_emit = 1'b1;
                    idle_res.action = ACT_START;
                end
                CH_RBRACK, CH_RBRACE: begin
                    idle_emit = 1'b1;
                    idle_res.action = ACT_STOP;
                end
                CH_LOW_R, CH_UP_R: begin
                    idle_emit = 1'b1;
                    idle_res.action = ACT_READ;
                end
                CH_SPACE, CH_COMMA, CH_LF, CH_CR: ;
                default: begin
                    if (i_char inside {[CH_ZERO:CH_DIG_HI]}) begin
                        n_tok  = tok_absorb(TOK_CLEAR, i_char);
                        n_mode = MODE_TOKEN;
                        if (i_eos) begin
                            idle_emit       = 1'b1;
                            idle_res.action = ACT_WRITE;
                            idle_res.value  = tok_value(tok_absorb(TOK_CLEAR, i_char));
                        end
                    end else begin
                        idle_emit       = 1'b1;
                        idle_res.action = ACT_ERROR;
                        n_mode          = MODE_ERROR;
                    end
                end
            endcase
        end

        if (i_eos) begin
            n_mode = MODE_IDLE;
        end
    end

    // Order the results, close token write first
    always_comb begin
        push = '0;
        if (tok_emit && idle_emit) begin
            push.count   = 2'd2;
            push.r0      = tok_res;
            push.r1      = idle_res;
            push.r1.last = 1'b1;
        end else if (tok_emit) begin
            push.count   = 2'd1;
            push.r0      = tok_res;
            push.r0.last = 1'b1;
        end else if (idle_emit) begin
            push.count   = 2'd1;
            push.r0      = idle_res;
            push.r0.last = 1'b1;
        end
        if (!i_accept) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    // Advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_tok  <= TOK_CLEAR;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_tok  <= n_tok;
        end
    end

endmodule

>>> design/bcsp_result_fifo.sv
// ----------------------------------------------------------------------------
// bcsp_result_fifo: result queue
// Small register queue that takes up to two results per cycle and hands
// out one per output transaction.
// ----------------------------------------------------------------------------
module bcsp_result_fifo
    import bcsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_room_two
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic [FIFO_AW-1:0]   wr_next;
    logic                 pop;

    assign o_valid    = (r_count != '0);
    assign o_res      = r_mem[r_rd];
    assign o_room_two = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign pop        = o_valid && i_ready;
    assign wr_next    = r_wr + FIFO_AW'(1);

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.count);
        n_rd    = r_rd + FIFO_AW'(pop);
        n_count = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the new results
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

endmodule

>>> design/bus_command_string_parser.sv
// ----------------------------------------------------------------------------
// bus_command_string_parser: ASCII command string to bus actions
// A result is written into the result queue when its character is accepted.
// Throughput: one character per cycle; a character raising two results needs
// two output transactions, and input stalls while the four-entry queue has
// room for fewer than two results. Reset (synchronous, active low) returns
// the parser to idle and empties the queue.
// ----------------------------------------------------------------------------
module bus_command_string_parser
    import bcsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] write_value
    output logic [2:0]  m_axis_tuser,   // [2:0] action
    output logic        m_axis_tlast    // end_of_run
);

    logic    accept;
    logic    room_two;
    t_push   push;
    t_result res;

    assign s_axis_tready = room_two;
    assign accept        = s_axis_tvalid && room_two;

    // Decode characters
    bcsp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .o_push   (push)
    );

    // Queue results
    bcsp_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_res      (res),
        .o_room_two (room_two)
    );

    assign m_axis_tdata = res.value;
    assign m_axis_tuser = res.action;
    assign m_axis_tlast = res.last;

endmodule

>>> design/bcsp_checker.sv
// ----------------------------------------------------------------------------
// bcsp_checker: port-level checks for the command string parser
// Watches the output channel for well-formed result transactions.
// ----------------------------------------------------------------------------
module bcsp_checker
    import bcsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Action codes stay in range
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ACT_ERROR))
        else $error("bad action code");

    // Only writes carry a byte
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ACT_WRITE) |-> m_axis_tdata == 8'd0)
        else $error("non-write result carries a byte");

    // A result not closing its run is a token write followed by its partner
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ACT_WRITE)
        else $error("first of a pair is not a write");

    // Nothing is offered in the cycle after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

endmodule

bind bus_command_string_parser bcsp_checker u_bcsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the bus command string parser
// Feeds command strings, one character per input transaction, and checks
// every bus action that comes back against a cycle-free predictor of the
// parser. Directed strings come first. Random strings follow: mostly
// well-formed, with some broken and noisy ones. Both sides of the stream
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import bcsp_pkg::*;

    // Letters that bound the hex digit ranges
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } char_item_t;

    typedef struct packed {
        t_action    action;
        logic [7:0] value;
        logic       last;
    } bus_op_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] character
    logic        s_axis_tlast = 1'b0;   // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] write_value
    logic [2:0]  m_axis_tuser;          // [2:0] action
    logic        m_axis_tlast;          // end_of_run

    bus_command_string_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    char_item_t  pending_chars [$];
    bus_op_t     expected_ops [$];
    logic [7:0]  cmd_text [$];
    char_item_t  next_item;
    bus_op_t     got_op;
    logic        char_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          chars_queued = 0;
    int          mismatches = 0;

    // Parser state as predicted
    t_mode       parse_state = MODE_IDLE;
    logic [1:0]  tok_pos = 2'd0;
    t_kind       tok_radix = KIND_DEC;
    logic [7:0]  tok_dec = 8'd0;
    logic [7:0]  tok_hex = 8'd0;
    logic [7:0]  tok_bin = 8'd0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit is_token_char(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_DIG_HI) || (c >= CH_UP_A && c <= CH_UP_F) ||
               (c >= CH_LOW_A && c <= CH_LOW_F) || c == CH_LOW_X || c == CH_LOW_H ||
               c == CH_CARET || c == CH_AMP || c == CH_LOW_R;
    endfunction

    function automatic logic [7:0] token_byte();
        if (tok_radix == KIND_HEX) return tok_hex;
        if (tok_radix == KIND_BIN) return tok_bin;
        return tok_dec;
    endfunction

    // Fold one character into the radix accumulators, mod 256; hex and binary from the third on
    task automatic take_token_char(input logic [7:0] c);
        logic [7:0] digit;
        tok_dec = tok_dec * 8'd10 + (c - CH_ZERO);
        if (tok_pos == 2'd1) begin
            if (c == CH_LOW_X || c == CH_LOW_H) begin
                tok_radix = KIND_HEX;
            end else if (c == CH_LOW_B) begin
                tok_radix = KIND_BIN;
            end else begin
                tok_radix = KIND_DEC;
            end
        end else if (tok_pos == 2'd2) begin
            if (c < CH_AT) begin
                digit = c - CH_ZERO;
            end else if (c < CH_UP_G) begin
                digit = c - HEX_UP_OFS;
            end else begin
                digit = c - HEX_LOW_OFS;
            end
            tok_hex = tok_hex * 8'd16 + digit;
            tok_bin = {tok_bin[6:0], (c == CH_ONE)};
        end
        if (tok_pos != 2'd2) tok_pos = tok_pos + 2'd1;
    endtask

    // Work out the bus actions raised by one accepted character
    task automatic interpret_char(input logic [7:0] c, input logic eos);
        bus_op_t ops [2];
        int      n_ops;
        bit      as_idle;
        n_ops   = 0;
        as_idle = 1'b1;
        if (parse_state == MODE_ERROR) begin
            as_idle = 1'b0;
        end else if (parse_state == MODE_TOKEN) begin
            if (is_token_char(c)) begin
                take_token_char(c);
                if (eos) begin
                    ops[n_ops] = '{ACT_WRITE, token_byte(), 1'b0};
                    n_ops++;
                end
                as_idle = 1'b0;
            end else begin
                // closing character: write first, then handle it as if idle
                ops[n_ops] = '{ACT_WRITE, token_byte(), 1'b0};
                n_ops++;
                parse_state = MODE_IDLE;
            end
        end
        if (as_idle) begin
            case (c)
                CH_LBRACK, CH_LBRACE: begin
                    ops[n_ops] = '{ACT_START, 8'd0, 1'b0};
                    n_ops++;
                end
                CH_RBRACK, CH_RBRACE: begin
                    ops[n_ops] = '{ACT_STOP, 8'd0, 1'b0};
                    n_ops++;
                end
                CH_LOW_R, CH_UP_R: begin
                    ops[n_ops] = '{ACT_READ, 8'd0, 1'b0};
                    n_ops++;
                end
                CH_SPACE, CH_COMMA, CH_LF, CH_CR: begin
                end
                default: begin
                    if (c >= CH_ZERO && c <= CH_DIG_HI) begin
                        tok_pos   = 2'd0;
                        tok_radix = KIND_DEC;
                        tok_dec   = 8'd0;
                        tok_hex   = 8'd0;
                        tok_bin   = 8'd0;
                        take_token_char(c);
                        parse_state = MODE_TOKEN;
                        if (eos) begin
                            ops[n_ops] = '{ACT_WRITE, token_byte(), 1'b0};
                            n_ops++;
                        end
                    end else begin
                        ops[n_ops] = '{ACT_ERROR, 8'd0, 1'b0};
                        n_ops++;
                        parse_state = MODE_ERROR;
                    end
                end
            endcase
        end
        if (eos) parse_state = MODE_IDLE;
        for (int k = 0; k < n_ops; k++) begin
            ops[k].last = (k == n_ops - 1);
            expected_ops.push_back(ops[k]);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] c, input logic eos);
        pending_chars.push_back('{c, eos});
        chars_queued++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) push_char(s[k], k == s.len() - 1);
    endtask

    // Flush the composed string, end of string on its last character
    task automatic send_cmd_text();
        for (int k = 0; k < cmd_text.size(); k++) push_char(cmd_text[k], k == cmd_text.size() - 1);
    endtask

    function automatic logic [7:0] pick_hex_digit();
        int sel;
        sel = $urandom_range(21);
        if (sel < 10) return 8'(CH_ZERO + sel);
        if (sel < 16) return 8'(CH_UP_A + sel - 10);
        return 8'(CH_LOW_A + sel - 16);
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_COMMA;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Any character that keeps a token open
    function automatic logic [7:0] pick_token_char();
        case ($urandom_range(8))
            0, 1:    return 8'(CH_ZERO + $urandom_range(15));
            2:       return 8'(CH_UP_A + $urandom_range(5));
            3:       return 8'(CH_LOW_A + $urandom_range(5));
            4:       return CH_LOW_X;
            5:       return CH_LOW_H;
            6:       return CH_CARET;
            7:       return CH_AMP;
            default: return CH_LOW_R;
        endcase
    endfunction

    task automatic append_number();
        int len;
        len = $urandom_range(1, 4);
        case ($urandom_range(3))
            0: begin
                for (int k = 0; k < len; k++)
                    cmd_text.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
            1: begin
                cmd_text.push_back($urandom_range(3) == 0 ?
                                   8'(CH_ZERO + $urandom_range(9)) : CH_ZERO);
                cmd_text.push_back($urandom_range(1) ? CH_LOW_X : CH_LOW_H);
                for (int k = 0; k < $urandom_range(1, 3); k++) cmd_text.push_back(pick_hex_digit());
            end
            2: begin
                cmd_text.push_back(CH_ZERO);
                cmd_text.push_back(CH_LOW_B);
                for (int k = 0; k < $urandom_range(1, 9); k++)
                    cmd_text.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
            end
            default: begin
                cmd_text.push_back(8'(CH_ZERO + $urandom_range(15)));
                for (int k = 1; k < len; k++) cmd_text.push_back(pick_token_char());
            end
        endcase
    endtask

    // Build one command string; noisy strings carry stray or broken characters
    task automatic compose_command();
        int n_parts;
        int top_kind;
        cmd_text.delete();
        if ($urandom_range(9) == 0) begin
            for (int k = 0; k < $urandom_range(1, 5); k++)
                cmd_text.push_back(8'($urandom_range(255)));
        end else begin
            top_kind = ($urandom_range(9) < 2) ? 9 : 8;
            n_parts  = $urandom_range(1, 6);
            for (int p = 0; p < n_parts; p++) begin
                case ($urandom_range(top_kind))
                    0, 1: cmd_text.push_back($urandom_range(1) ? CH_LBRACK : CH_LBRACE);
                    2:    cmd_text.push_back($urandom_range(1) ? CH_RBRACK : CH_RBRACE);
                    3:    cmd_text.push_back($urandom_range(1) ? CH_LOW_R : CH_UP_R);
                    4, 5, 6, 7: begin
                        append_number();
                        if ($urandom_range(3) != 0) cmd_text.push_back(pick_separator());
                    end
                    8:    cmd_text.push_back(pick_separator());
                    default: begin
                        if ($urandom_range(1))
                            cmd_text.push_back(8'($urandom_range(255)));
                        else
                            cmd_text.push_back(8'($urandom_range(CH_STAR, CH_SLASH)));
                    end
                endcase
            end
        end
        send_cmd_text();
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            // advance once the held character has gone
            if (!s_axis_tvalid || char_taken) begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_chars.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.ch;
                    s_axis_tlast  <= next_item.eos;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both sides on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        char_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_ops.size() == 0) begin
                $error("unexpected result transaction: tuser %h tdata %h tlast %b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                got_op = expected_ops.pop_front();
                if (m_axis_tuser != got_op.action) begin
                    $error("action mismatch: expected %0d, got %0d",
                           got_op.action, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata != got_op.value) begin
                    $error("write_value mismatch: expected %0d, got %0d",
                           got_op.value, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast != got_op.last) begin
                    $error("end_of_run mismatch: expected %0d, got %0d",
                           got_op.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            interpret_char(s_axis_tdata, s_axis_tlast);
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed strings, then three idling phases
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 56;
        send_text("[0x5A,");     // start, hex write closed by a separator
        send_text("{255}");      // decimal write closed by stop
        send_text("0b1011R");    // binary write closed by read
        send_text("7");          // one-character token at end of string
        send_text("0hfe");       // lower-case hex at end of string
        send_text("*q");         // error char, rest of string dropped
        send_text("9/");         // token closed by an error char
        push_char(8'hFF, 1'b1);
        send_text(" \r\n");      // separators only

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 56;
                recv_idle_pct = 10;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (chars_queued < 550 * (phase + 1)) compose_command();
            while (pending_chars.size() != 0) @(posedge i_clk);
        end

        // drain: last character gone, then every result back
        while (s_axis_tvalid) @(posedge i_clk);
        while (expected_ops.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_200_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
